FILE: design/ddm_pkg.sv
`default_nettype none

package ddm_pkg;

    // Operand size bound and digit format
    localparam int DEF_MAX_DIGITS = 32;
    localparam int DIGIT_W        = 4;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

    // Column accumulator: 32 pair products of 81 plus the incoming carry stay below 4096
    localparam int ACC_W = 12;
    localparam int RADIX = 10;

    // Divide by ten as multiply by ceil(2^15 / 10), exact for all ACC_W-bit values
    localparam int RECIP_W     = 12;
    localparam int RECIP_SHIFT = 15;
    localparam logic [RECIP_W-1:0] RECIP_TEN = 12'd3277;

    // Sequencer commands to the column unit
    typedef struct packed {
        logic clr;    // start a new multiply, no carry in
        logic mac;    // add one digit-pair product
        logic div;    // form column quotient (carry out)
        logic split;  // emit column digit, keep carry
    } col_ctrl_t;

endpackage

`default_nettype wire

FILE: design/ddm_digit_ram.sv
`default_nettype none

module ddm_digit_ram
    import ddm_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_DIGITS,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  wire logic               clk,
    input  wire logic               we,
    input  wire logic [AW-1:0]      waddr,
    input  wire logic [DIGIT_W-1:0] wdata,
    input  wire logic               re,
    input  wire logic [AW-1:0]      raddr,
    output logic      [DIGIT_W-1:0] rdata
);

    logic [DIGIT_W-1:0] mem_reg [DEPTH];
    logic [DIGIT_W-1:0] rdata_reg;

    // One write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // One registered read port, holds between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: design/ddm_column_acc.sv
`default_nettype none

module ddm_column_acc
    import ddm_pkg::*;
(
    input  wire logic               clk,
    input  wire col_ctrl_t          ctrl,
    input  wire logic [DIGIT_W-1:0] a_digit,
    input  wire logic [DIGIT_W-1:0] b_digit,
    output logic      [DIGIT_W-1:0] col_digit
);

    logic [ACC_W-1:0]         acc_reg, acc_next;
    logic [ACC_W-1:0]         quo_reg, quo_next;
    logic [2*DIGIT_W-1:0]     pair_prod;
    logic [ACC_W+RECIP_W-1:0] recip_prod;
    logic [ACC_W-1:0]         quo_times_ten;
    logic [ACC_W-1:0]         rem;

    // Digit-pair product, one per cycle
    assign pair_prod = {{DIGIT_W{1'b0}}, a_digit} * {{DIGIT_W{1'b0}}, b_digit};

    // Quotient by ten from the reciprocal
    assign recip_prod = {{RECIP_W{1'b0}}, acc_reg} * {{ACC_W{1'b0}}, RECIP_TEN};

    // Remainder is the column digit
    assign quo_times_ten = ACC_W'(quo_reg * ACC_W'(RADIX));
    assign rem           = acc_reg - quo_times_ten;
    assign col_digit     = rem[DIGIT_W-1:0];

    always_comb
    begin
        acc_next = acc_reg;
        quo_next = quo_reg;
        if (ctrl.clr)
        begin
            acc_next = '0;
        end
        else if (ctrl.mac)
        begin
            acc_next = acc_reg + {{(ACC_W-2*DIGIT_W){1'b0}}, pair_prod};
        end
        else if (ctrl.split)
        begin
            // carry seeds the next column
            acc_next = quo_reg;
        end
        if (ctrl.div)
        begin
            quo_next = ACC_W'(recip_prod >> RECIP_SHIFT);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        quo_reg <= quo_next;
    end

endmodule

`default_nettype wire

FILE: design/decimal_digit_multiplier_top.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_ready  kind, digit, negative, last
// output    out        out_valid/out_ready  product_digit, product_negative, last_digit, too_long
//
// Loading accepts one digit request per cycle.
// The multiply walks the columns: each digit pair is read from the operand RAMs, then
// added; each column then divides by ten and splits into a digit and a carry.
// Each product digit is read from the result RAM, then shown until the output takes it.
// No input request is taken from the final second-operand digit until the last
// product digit is taken. Reset clears counts, flags and the sequencer; RAMs are not cleared.

module decimal_digit_multiplier_top
    import ddm_pkg::*;
#(
    parameter int MAX_DIGITS = DEF_MAX_DIGITS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               kind,
    input  wire logic [DIGIT_W-1:0] digit,
    input  wire logic               negative,
    input  wire logic               last,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic      [DIGIT_W-1:0] product_digit,
    output logic                    product_negative,
    output logic                    last_digit,
    output logic                    too_long
);

    localparam int AW    = $clog2(MAX_DIGITS);
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int RDEP  = 2 * MAX_DIGITS;
    localparam int RAW   = $clog2(RDEP);
    localparam int COL_W = $clog2(RDEP + 1);

    typedef enum logic [6:0] {
        S_LOAD      = 7'b0000001,
        S_MAC_RD    = 7'b0000010,
        S_MAC_ADD   = 7'b0000100,
        S_DIV       = 7'b0001000,
        S_SPLIT     = 7'b0010000,
        S_EMIT_RD   = 7'b0100000,
        S_EMIT_SHOW = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] fc_reg, fc_next;
    logic [CNT_W-1:0] sc_reg, sc_next;
    logic             sign1_reg, sign1_next;
    logic             sign2_reg, sign2_next;
    logic             err_reg, err_next;
    logic [COL_W-1:0] c_reg, c_next;
    logic [CNT_W-1:0] b_reg, b_next;
    logic [COL_W-1:0] top_reg, top_next;
    logic             nz_reg, nz_next;
    logic [COL_W-1:0] p_reg, p_next;

    logic               in_fire, out_fire;
    logic [DIGIT_W-1:0] dclamp;
    logic [COL_W-1:0]   fc_ext, sc_ext, b_ext, ncol, c_inc, idx_a, b_hi_ext, b_lo_ext;
    logic [CNT_W-1:0]   b_hi, b_lo_inc;
    logic               fc_full, sc_full;

    logic               a_we, b_we, r_we, op_re, r_re;
    logic [AW-1:0]      a_raddr, b_raddr;
    logic [DIGIT_W-1:0] a_rdata, b_rdata, res_rdata, col_digit;
    col_ctrl_t          col_ctrl;

    assign in_ready  = (state_reg == S_LOAD);
    assign out_valid = (state_reg == S_EMIT_SHOW);
    assign in_fire   = in_valid & in_ready;
    assign out_fire  = out_valid & out_ready;

    // Input digit clamp and store limits
    assign dclamp  = (digit > DIGIT_MAX) ? DIGIT_MAX : digit;
    assign fc_full = (fc_reg >= CNT_W'(MAX_DIGITS));
    assign sc_full = (sc_reg >= CNT_W'(MAX_DIGITS));

    // Column walk: column c pairs first weight c-b with second weight b
    assign fc_ext   = {{(COL_W-CNT_W){1'b0}}, fc_reg};
    assign sc_ext   = {{(COL_W-CNT_W){1'b0}}, sc_reg};
    assign b_ext    = {{(COL_W-CNT_W){1'b0}}, b_reg};
    assign ncol     = fc_ext + sc_ext;
    assign c_inc    = c_reg + COL_W'(1);
    assign idx_a    = fc_ext - COL_W'(1) - c_reg + b_ext;
    assign a_raddr  = idx_a[AW-1:0];
    assign b_raddr  = AW'(sc_reg - CNT_W'(1) - b_reg);
    assign b_hi_ext = (c_reg < sc_ext) ? c_reg : (sc_ext - COL_W'(1));
    assign b_hi     = b_hi_ext[CNT_W-1:0];
    assign b_lo_ext = (c_inc >= fc_ext) ? (c_inc - fc_ext + COL_W'(1)) : '0;
    assign b_lo_inc = b_lo_ext[CNT_W-1:0];

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        fc_next    = fc_reg;
        sc_next    = sc_reg;
        sign1_next = sign1_reg;
        sign2_next = sign2_reg;
        err_next   = err_reg;
        c_next     = c_reg;
        b_next     = b_reg;
        top_next   = top_reg;
        nz_next    = nz_reg;
        p_next     = p_reg;
        a_we       = 1'b0;
        b_we       = 1'b0;
        r_we       = 1'b0;
        op_re      = 1'b0;
        r_re       = 1'b0;
        col_ctrl   = '0;

        case (state_reg)
            S_LOAD:
            begin
                if (in_fire)
                begin
                    if (!kind)
                    begin
                        if (fc_full)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            a_we    = 1'b1;
                            fc_next = fc_reg + CNT_W'(1);
                        end
                        if (last)
                        begin
                            sign1_next = negative;
                        end
                    end
                    else
                    begin
                        if (sc_full)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            b_we    = 1'b1;
                            sc_next = sc_reg + CNT_W'(1);
                        end
                        if (last)
                        begin
                            sign2_next   = negative;
                            col_ctrl.clr = 1'b1;
                            c_next       = '0;
                            b_next       = '0;
                            top_next     = '0;
                            nz_next      = 1'b0;
                            p_next       = '0;
                            // empty first operand: product is zero
                            state_next   = (fc_reg == '0) ? S_EMIT_RD : S_MAC_RD;
                        end
                    end
                end
            end

            S_MAC_RD:
            begin
                op_re      = 1'b1;
                state_next = S_MAC_ADD;
            end

            S_MAC_ADD:
            begin
                col_ctrl.mac = 1'b1;
                if (b_reg == b_hi)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    b_next     = b_reg + CNT_W'(1);
                    state_next = S_MAC_RD;
                end
            end

            S_DIV:
            begin
                col_ctrl.div = 1'b1;
                state_next   = S_SPLIT;
            end

            S_SPLIT:
            begin
                col_ctrl.split = 1'b1;
                r_we           = 1'b1;
                if (col_digit != '0)
                begin
                    top_next = c_reg;
                    nz_next  = 1'b1;
                end
                if (c_reg == ncol - COL_W'(1))
                begin
                    p_next     = (col_digit != '0) ? c_reg : top_reg;
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    c_next = c_inc;
                    b_next = b_lo_inc;
                    // top column holds only the carry
                    state_next = (c_inc == ncol - COL_W'(1)) ? S_DIV : S_MAC_RD;
                end
            end

            S_EMIT_RD:
            begin
                r_re       = 1'b1;
                state_next = S_EMIT_SHOW;
            end

            S_EMIT_SHOW:
            begin
                if (out_fire)
                begin
                    if (p_reg == '0)
                    begin
                        fc_next    = '0;
                        sc_next    = '0;
                        sign1_next = 1'b0;
                        err_next   = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        p_next     = p_reg - COL_W'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            fc_reg    <= '0;
            sc_reg    <= '0;
            sign1_reg <= 1'b0;
            sign2_reg <= 1'b0;
            err_reg   <= 1'b0;
            c_reg     <= '0;
            b_reg     <= '0;
            top_reg   <= '0;
            nz_reg    <= 1'b0;
            p_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fc_reg    <= fc_next;
            sc_reg    <= sc_next;
            sign1_reg <= sign1_next;
            sign2_reg <= sign2_next;
            err_reg   <= err_next;
            c_reg     <= c_next;
            b_reg     <= b_next;
            top_reg   <= top_next;
            nz_reg    <= nz_next;
            p_reg     <= p_next;
        end
    end

    // Operand digit stores
    ddm_digit_ram #(
        .DEPTH (MAX_DIGITS),
        .AW    (AW)
    ) u_first_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (fc_reg[AW-1:0]),
        .wdata (dclamp),
        .re    (op_re),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    ddm_digit_ram #(
        .DEPTH (MAX_DIGITS),
        .AW    (AW)
    ) u_second_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (sc_reg[AW-1:0]),
        .wdata (dclamp),
        .re    (op_re),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // Column accumulate and carry
    ddm_column_acc u_column (
        .clk       (clk),
        .ctrl      (col_ctrl),
        .a_digit   (a_rdata),
        .b_digit   (b_rdata),
        .col_digit (col_digit)
    );

    // Product digit store, least significant column at address zero
    ddm_digit_ram #(
        .DEPTH (RDEP),
        .AW    (RAW)
    ) u_result_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (c_reg[RAW-1:0]),
        .wdata (col_digit),
        .re    (r_re),
        .raddr (p_reg[RAW-1:0]),
        .rdata (res_rdata)
    );

    // Result payload
    assign product_digit    = nz_reg ? res_rdata : '0;
    assign product_negative = nz_reg & (sign1_reg ^ sign2_reg);
    assign last_digit       = (p_reg == '0);
    assign too_long         = err_reg;

    // Checks
    a_no_load_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while product digits pending");

    a_zero_single_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !nz_reg) |-> (p_reg == '0))
        else $error("zero product longer than one digit");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fc_reg <= CNT_W'(MAX_DIGITS)) && (sc_reg <= CNT_W'(MAX_DIGITS)))
        else $error("operand count beyond store depth");

    a_last_ends_product: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && last_digit) |=> in_ready && (fc_reg == '0) && (sc_reg == '0))
        else $error("operand state not cleared after product");

endmodule

`default_nettype wire
